>>> src/gpbtb_pkg.sv
`default_nettype none

package gpbtb_pkg;

	localparam int HISTORY_BITS_DEF  = 10;
	localparam int TABLE_ENTRIES_DEF = 1024;
	localparam int BTB_ENTRIES_DEF   = 64;

	localparam int PC_W     = 32;
	localparam int IDX_W    = 10;
	localparam int CFG_W    = 7;
	localparam int PC_SHIFT = 3;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;
	localparam logic [1:0]       CTR_INIT  = 2'd2;
	localparam logic [1:0]       CTR_MAX   = 2'd3;
	localparam logic [1:0]       CTR_MIN   = 2'd0;

	localparam logic ACT_PREDICT = 1'b0;
	localparam logic ACT_UPDATE  = 1'b1;

	typedef struct packed {
		logic            action;
		logic [PC_W-1:0] pc;
		logic [IDX_W-1:0] saved_index;
		logic            outcome_taken;
		logic [PC_W-1:0] resolved_target;
	} in_t;

	typedef struct packed {
		logic [IDX_W-1:0] table_index;
		logic             predict_taken;
		logic             target_found;
		logic [PC_W-1:0]  predicted_target;
	} out_t;

	typedef struct packed {
		logic cap;
		logic clr;
		logic ctr_rd;
		logic ctr_use;
		logic ctr_wr;
		logic srch_clr;
		logic srch_step;
		logic srch_done;
		logic btb_wr;
		logic out_ld;
	} cmd_t;

	typedef struct packed {
		logic upd;
		logic pred;
		logic hit;
		logic last;
		logic clr_last;
	} sts_t;

endpackage

`default_nettype wire

>>> src/gpbtb_dp.sv
`default_nettype none

module gpbtb_dp #(
	parameter int HISTORY_BITS  = gpbtb_pkg::HISTORY_BITS_DEF,
	parameter int TABLE_ENTRIES = gpbtb_pkg::TABLE_ENTRIES_DEF,
	parameter int BTB_ENTRIES   = gpbtb_pkg::BTB_ENTRIES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  gpbtb_pkg::in_t                    in_data,
	input  wire                               cfg_we,
	input  wire  [gpbtb_pkg::CFG_W-1:0]       cfg_wdata,
	input  gpbtb_pkg::cmd_t                   cmd,
	output gpbtb_pkg::sts_t                   sts,
	output gpbtb_pkg::out_t                   out_data
);

	localparam int TW = $clog2(TABLE_ENTRIES);
	localparam int IW = (BTB_ENTRIES > 1) ? $clog2(BTB_ENTRIES) : 1;
	localparam int NW = $clog2(BTB_ENTRIES + 1);
	localparam int XW = (HISTORY_BITS > TW) ? HISTORY_BITS : TW;
	localparam int SW = (gpbtb_pkg::IDX_W > TW) ? gpbtb_pkg::IDX_W : TW;
	localparam int EW = 2 * gpbtb_pkg::PC_W;

	// entries in use, clamped to 1..BTB_ENTRIES
	function automatic logic [NW-1:0] clamp_n(logic [gpbtb_pkg::CFG_W-1:0] v);
		logic [8:0] w;
		w = 9'(v);
		if (w == 9'd0)
			return NW'(1);
		if (w > 9'(BTB_ENTRIES))
			return NW'(BTB_ENTRIES);
		return NW'(w);
	endfunction

	localparam logic [NW-1:0] N_RESET = clamp_n(gpbtb_pkg::CFG_RESET);

	gpbtb_pkg::in_t          item_q;
	logic [NW-1:0]           n_q;
	logic [HISTORY_BITS-1:0] hist_q;
	logic [TW-1:0]           clr_q;
	logic [TW-1:0]           ctr_idx_q;
	logic [1:0]              ctr_s1;
	logic                    pred_q;
	logic [1:0]              ctr_mem [TABLE_ENTRIES];

	logic [EW-1:0]           btb_mem [BTB_ENTRIES];
	logic [BTB_ENTRIES-1:0]  valid_q;
	logic [IW-1:0]           srch_q;
	logic [IW-1:0]           srch_s1;
	logic                    cmp_s1;
	logic [EW-1:0]           ent_s1;
	logic                    hit_q;
	logic [IW-1:0]           hit_idx_q;
	logic [gpbtb_pkg::PC_W-1:0] tgt_q;
	logic [IW-1:0]           ptr_q;
	gpbtb_pkg::out_t         out_q;

	logic [XW-1:0]           hash;
	logic [TW-1:0]           rd_addr;
	logic [TW-1:0]           wr_addr;
	logic [1:0]              wr_data;
	logic                    wr_en;
	logic [1:0]              ctr_nxt;
	logic [IW-1:0]           fill_idx;
	logic [IW-1:0]           btb_wr_idx;
	logic [NW-1:0]           ptr_inc;
	logic                    is_upd;
	logic                    found;

	assign is_upd = (item_q.action == gpbtb_pkg::ACT_UPDATE);

	assign hash = XW'(item_q.pc[gpbtb_pkg::PC_SHIFT +: HISTORY_BITS]) ^ XW'(hist_q);
	assign rd_addr = is_upd ? TW'(SW'(item_q.saved_index)) : hash[TW-1:0];

	always_comb begin
		if (item_q.outcome_taken) begin
			ctr_nxt = (ctr_s1 == gpbtb_pkg::CTR_MAX) ? ctr_s1 : ctr_s1 + 2'd1;
		end else begin
			ctr_nxt = (ctr_s1 == gpbtb_pkg::CTR_MIN) ? ctr_s1 : ctr_s1 - 2'd1;
		end
	end

	assign wr_en   = cmd.clr | cmd.ctr_wr;
	assign wr_addr = cmd.clr ? clr_q : ctr_idx_q;
	assign wr_data = cmd.clr ? gpbtb_pkg::CTR_INIT : ctr_nxt;

	always_ff @(posedge clk) begin
		if (wr_en)
			ctr_mem[wr_addr] <= wr_data;
		if (cmd.ctr_rd)
			ctr_s1 <= ctr_mem[rd_addr];
	end

	// fill slot wraps to 0 when the pointer sits beyond the entries in use
	assign fill_idx   = (NW'(ptr_q) >= n_q) ? '0 : ptr_q;
	assign ptr_inc    = NW'(fill_idx) + NW'(1);
	assign btb_wr_idx = hit_q ? hit_idx_q : fill_idx;

	always_ff @(posedge clk) begin
		if (cmd.btb_wr)
			btb_mem[btb_wr_idx] <= {item_q.pc, item_q.resolved_target};
		if (cmd.srch_step)
			ent_s1 <= btb_mem[srch_q];
	end

	assign sts.upd      = is_upd;
	assign sts.pred     = ctr_s1[1];
	assign sts.hit      = cmp_s1 && valid_q[srch_s1]
	                      && (ent_s1[EW-1 -: gpbtb_pkg::PC_W] == item_q.pc);
	assign sts.last     = cmp_s1 && (NW'(srch_s1) == n_q - NW'(1));
	assign sts.clr_last = (clr_q == TW'(TABLE_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= N_RESET;
			hist_q  <= '0;
			clr_q   <= '0;
			valid_q <= '0;
			ptr_q   <= '0;
			cmp_s1  <= 1'b0;
		end else begin
			if (cfg_we)
				n_q <= clamp_n(cfg_wdata);
			if (cmd.clr)
				clr_q <= clr_q + TW'(1);
			if (cmd.ctr_wr)
				hist_q <= {hist_q[HISTORY_BITS-2:0], item_q.outcome_taken};
			cmp_s1 <= cmd.srch_step;
			if (cmd.btb_wr) begin
				valid_q[btb_wr_idx] <= 1'b1;
				if (!hit_q)
					ptr_q <= (ptr_inc >= n_q) ? '0 : IW'(ptr_inc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap)
			item_q <= in_data;
		if (cmd.ctr_rd)
			ctr_idx_q <= rd_addr;
		if (cmd.ctr_use)
			pred_q <= ctr_s1[1];
		if (cmd.srch_clr)
			srch_q <= '0;
		else if (cmd.srch_step)
			srch_q <= srch_q + IW'(1);
		if (cmd.srch_step)
			srch_s1 <= srch_q;
		if (cmd.srch_done) begin
			hit_q     <= sts.hit;
			hit_idx_q <= srch_s1;
			tgt_q     <= ent_s1[gpbtb_pkg::PC_W-1:0];
		end
	end

	assign found = !is_upd && pred_q && hit_q;

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_q.table_index      <= is_upd ? '0 : gpbtb_pkg::IDX_W'(SW'(ctr_idx_q));
			out_q.predict_taken    <= !is_upd && pred_q;
			out_q.target_found     <= found;
			out_q.predicted_target <= found ? tgt_q : '0;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

>>> src/gpbtb_ctrl.sv
`default_nettype none

module gpbtb_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  wire              out_ready,
	input  gpbtb_pkg::sts_t  sts,
	output gpbtb_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CTR_RD,
		ST_CTR_USE,
		ST_SEARCH,
		ST_BTB_WR,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   srch_end;

	assign srch_end = sts.hit | sts.last;

	always_comb begin
		cmd           = '0;
		cmd.cap       = (state_q == ST_IDLE) && in_valid;
		cmd.clr       = (state_q == ST_CLEAR);
		cmd.ctr_rd    = (state_q == ST_CTR_RD);
		cmd.ctr_use   = (state_q == ST_CTR_USE);
		cmd.ctr_wr    = (state_q == ST_CTR_USE) && sts.upd;
		cmd.srch_clr  = (state_q == ST_CTR_USE);
		cmd.srch_step = (state_q == ST_SEARCH);
		cmd.srch_done = (state_q == ST_SEARCH) && srch_end;
		cmd.btb_wr    = (state_q == ST_BTB_WR);
		cmd.out_ld    = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.out_ld || (out_valid_q && !out_ready);
			case (state_q)
				ST_CLEAR: begin
					if (sts.clr_last)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_CTR_RD;
				end
				ST_CTR_RD: begin
					state_q <= ST_CTR_USE;
				end
				ST_CTR_USE: begin
					// not-taken predictions skip the btb
					if (sts.upd || sts.pred)
						state_q <= ST_SEARCH;
					else
						state_q <= ST_FINISH;
				end
				ST_SEARCH: begin
					if (srch_end)
						state_q <= sts.upd ? ST_BTB_WR : ST_FINISH;
				end
				ST_BTB_WR: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (cmd.out_ld)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/gshare_predictor_with_btb.sv
`default_nettype none

// Gshare branch predictor with a branch target buffer. Each input beat is a
// predict (pc in, hashed table index, taken bit and btb target out) or an update
// (counter training, history shift, btb write; its result beat is all zeros).
// Items are handled one at a time: a not-taken prediction passes through the
// counter read, counter use and finish states, and the next beat can be accepted
// once its result is loaded; taken predictions and updates add a linear btb
// search that compares entries up to and including the first match (at most
// btb_entries_in_use), and updates add a btb write state after the search.
// The search walks the single-port btb memory one entry a cycle. After reset,
// in_ready stays low while the counter table is swept to weakly taken; cfg
// writes are taken at any time. A finished result waits in an output register
// while the next item is accepted.
module gshare_predictor_with_btb #(
	parameter int HISTORY_BITS  = gpbtb_pkg::HISTORY_BITS_DEF,
	parameter int TABLE_ENTRIES = gpbtb_pkg::TABLE_ENTRIES_DEF,
	parameter int BTB_ENTRIES   = gpbtb_pkg::BTB_ENTRIES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  gpbtb_pkg::in_t               in_data,
	output logic                         out_valid,
	input  wire                          out_ready,
	output gpbtb_pkg::out_t              out_data,
	input  wire                          cfg_we,
	input  wire  [gpbtb_pkg::CFG_W-1:0]  cfg_wdata
);

	gpbtb_pkg::cmd_t cmd;
	gpbtb_pkg::sts_t sts;

	gpbtb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gpbtb_dp #(
		.HISTORY_BITS  (HISTORY_BITS),
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.BTB_ENTRIES   (BTB_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import gpbtb_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int WATCHDOG_MAX = 5000;
	localparam int HOLD_CYCLES  = 250;
	localparam int CFG_SETTLE   = 4;
	localparam int TAIL_CYCLES  = 100;
	localparam int POOL_SIZE    = 48;
	localparam int PHASE_ITEMS  = 165;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	in_t              in_data   = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	gshare_predictor_with_btb u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #HALF_PERIOD clk = ~clk;

	// predictor state, kept in step with accepted beats
	logic [1:0]                  pht      [TABLE_ENTRIES_DEF];
	logic [HISTORY_BITS_DEF-1:0] ghist;
	logic [PC_W-1:0]             btb_tags [BTB_ENTRIES_DEF];
	logic [PC_W-1:0]             btb_tgts [BTB_ENTRIES_DEF];
	logic                        btb_vld  [BTB_ENTRIES_DEF];
	logic [5:0]                  btb_ptr;
	logic [CFG_W-1:0]            btb_cfg;

	out_t answers_due[$];
	int   n_err        = 0;
	int   snd_idle_pct = 0;
	int   stall_pct    = 0;
	bit   hold_req     = 1'b0;
	logic hold_on      = 1'b0;
	int   idle_cycles  = 0;

	logic [PC_W-1:0] pc_pool   [POOL_SIZE];
	logic [PC_W-1:0] tgt_pool  [POOL_SIZE];
	int              bias_pool [POOL_SIZE];

	function automatic int entries_used();
		int n;
		n = int'(btb_cfg);
		if (n < 1) n = 1;
		if (n > BTB_ENTRIES_DEF) n = BTB_ENTRIES_DEF;
		return n;
	endfunction

	function automatic int btb_find(input logic [PC_W-1:0] pc);
		int n;
		n = entries_used();
		for (int i = 0; i < n; i++)
			if (btb_vld[i] && btb_tags[i] == pc) return i;
		return -1;
	endfunction

	function automatic out_t gshare_answer(input in_t it);
		out_t r;
		int   idx;
		int   hit;
		int   n;
		int   p;
		r = '0;
		if (it.action == ACT_PREDICT) begin
			idx = int'(it.pc[PC_SHIFT +: HISTORY_BITS_DEF] ^ ghist) % TABLE_ENTRIES_DEF;
			r.table_index   = IDX_W'(idx);
			// upper counter bit set means taken
			r.predict_taken = pht[idx][1];
			if (r.predict_taken) begin
				hit = btb_find(it.pc);
				if (hit >= 0) begin
					r.target_found     = 1'b1;
					r.predicted_target = btb_tgts[hit];
				end
			end
		end else begin
			idx = int'(it.saved_index) % TABLE_ENTRIES_DEF;
			if (it.outcome_taken) begin
				if (pht[idx] != CTR_MAX) pht[idx] = pht[idx] + 2'd1;
			end else begin
				if (pht[idx] != CTR_MIN) pht[idx] = pht[idx] - 2'd1;
			end
			ghist = {ghist[HISTORY_BITS_DEF-2:0], it.outcome_taken};
			hit = btb_find(it.pc);
			if (hit >= 0) begin
				btb_tgts[hit] = it.resolved_target;
			end else begin
				n = entries_used();
				p = int'(btb_ptr);
				if (p >= n) p = 0;
				btb_tags[p] = it.pc;
				btb_tgts[p] = it.resolved_target;
				btb_vld[p]  = 1'b1;
				p++;
				if (p >= n) p = 0;
				btb_ptr = 6'(p);
			end
		end
		return r;
	endfunction

	function automatic in_t random_item(input logic act, input logic [PC_W-1:0] pc);
		in_t it;
		it.action          = act;
		it.pc              = pc;
		it.saved_index     = IDX_W'($urandom_range(0, TABLE_ENTRIES_DEF - 1));
		it.outcome_taken   = 1'($urandom_range(0, 1));
		it.resolved_target = $urandom;
		return it;
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want);
		n_err++;
		if (n_err <= 100)
			$display("mismatch: %s got %0h expected %0h", what, got, want);
	endtask

	task automatic send_item(input in_t it, output out_t ans);
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		ans = gshare_answer(it);
		answers_due.push_back(ans);
	endtask

	task automatic send_predict(input logic [PC_W-1:0] pc, output out_t ans);
		send_item(random_item(ACT_PREDICT, pc), ans);
	endtask

	task automatic send_update(input logic [PC_W-1:0] pc, input logic [IDX_W-1:0] idx,
			input logic taken, input logic [PC_W-1:0] tgt);
		in_t  it;
		out_t ans;
		it = random_item(ACT_UPDATE, pc);
		it.saved_index     = idx;
		it.outcome_taken   = taken;
		it.resolved_target = tgt;
		send_item(it, ans);
	endtask

	task automatic drain_answers();
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_btb_entries(input logic [CFG_W-1:0] v);
		drain_answers();
		// let a trailing btb write finish before the count changes
		repeat (CFG_SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		btb_cfg = v;
	endtask

	task automatic test_directed_counters_and_btb();
		out_t            ans;
		logic [PC_W-1:0] quiet_pc;
		snd_idle_pct = 0;
		stall_pct <= 0;
		write_btb_entries(CFG_RESET);
		send_predict(32'h0000_0000, ans);
		send_update(32'h0000_0000, 10'h000, 1'b1, 32'hFFFF_FFFF);
		send_update(32'hFFFF_FFFF, 10'h3FF, 1'b0, 32'h0000_0000);
		send_update(32'hFFFF_FFFF, 10'h3FF, 1'b0, $urandom);
		// counter already at zero
		send_update(32'hFFFF_FFFF, 10'h3FF, 1'b0, $urandom);
		// counter already at three
		send_update(32'h0000_0000, 10'h000, 1'b1, 32'h0000_0000);
		send_predict(32'h0000_0000, ans);
		send_predict(32'hFFFF_FFFF, ans);
		// pc in the btb but its hashed counter trained down: no target
		quiet_pc = {19'h2D2D2, 10'h2AA ^ {ghist[7:0], 2'b00}, 3'b101};
		send_update(quiet_pc, 10'h2AA, 1'b0, $urandom);
		send_update(quiet_pc, 10'h2AA, 1'b0, $urandom);
		send_predict(quiet_pc, ans);
		drain_answers();
	endtask

	task automatic test_btb_capacity_edges();
		out_t            ans;
		logic [PC_W-1:0] pa;
		logic [PC_W-1:0] pb;
		logic [PC_W-1:0] p1;
		logic [PC_W-1:0] p2;
		logic [PC_W-1:0] p3;
		pa = 32'h0000_1000;
		pb = 32'h0000_2008;
		p1 = 32'h4000_0040;
		p2 = 32'h4000_0080;
		p3 = 32'h4000_00C0;
		// zero acts as one entry
		write_btb_entries(7'd0);
		send_update(pa, IDX_W'(pa >> PC_SHIFT), 1'b1, $urandom);
		send_update(pb, IDX_W'(pb >> PC_SHIFT), 1'b1, $urandom);
		send_predict(pa, ans);
		send_predict(pb, ans);
		write_btb_entries(7'd4);
		send_update(p1, IDX_W'(p1 >> PC_SHIFT), 1'b1, $urandom);
		send_update(p2, IDX_W'(p2 >> PC_SHIFT), 1'b1, $urandom);
		send_update(p3, IDX_W'(p3 >> PC_SHIFT), 1'b1, $urandom);
		send_predict(p3, ans);
		// pointer now beyond the count, p3 lands in entry 0 and stays in entry 2
		write_btb_entries(7'd2);
		send_update(p3, IDX_W'(p3 >> PC_SHIFT), 1'b1, $urandom);
		send_predict(p2, ans);
		send_predict(p1, ans);
		write_btb_entries(7'd1);
		send_predict(p2, ans);
		// above the btb size acts as the full btb, lowest duplicate wins
		write_btb_entries(7'd127);
		send_predict(p3, ans);
		send_predict(p2, ans);
		drain_answers();
	endtask

	task automatic run_branch_mix(input int n_items);
		int   sent;
		int   k;
		int   r;
		in_t  it;
		out_t ans;
		sent = 0;
		while (sent < n_items) begin
			k = $urandom_range(0, POOL_SIZE - 1);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				// predict then resolve the same branch with the returned index
				send_predict(pc_pool[k], ans);
				if ($urandom_range(0, 3) == 0) tgt_pool[k] = $urandom;
				send_update(pc_pool[k], ans.table_index,
					$urandom_range(0, 99) < bias_pool[k], tgt_pool[k]);
				sent += 2;
			end else if (r < 85) begin
				send_predict($urandom_range(0, 1) ? pc_pool[k] : $urandom, ans);
				sent += 1;
			end else begin
				it = random_item(ACT_UPDATE, $urandom_range(0, 1) ? pc_pool[k] : $urandom);
				send_item(it, ans);
				sent += 1;
			end
		end
	endtask

	task automatic test_output_backpressure();
		out_t ans;
		write_btb_entries(7'd16);
		snd_idle_pct = 0;
		stall_pct <= 0;
		hold_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_item(random_item(i[0] ? ACT_UPDATE : ACT_PREDICT, pc_pool[i % 8]), ans);
		while (hold_req) @(posedge clk);
		drain_answers();
		snd_idle_pct = 19;
		stall_pct <= 19;
		run_branch_mix(30);
		drain_answers();
	endtask

	task automatic test_random_phases();
		logic [CFG_W-1:0] cfgs [8];
		cfgs = '{7'd64, 7'd1, 7'd127, 7'd0, 7'd8, 7'd33, 7'd3, 7'd64};
		cfgs[5] = 7'($urandom_range(2, 63));
		for (int ph = 0; ph < 8; ph++) begin
			write_btb_entries(cfgs[ph]);
			case (ph % 4)
				0: begin
					snd_idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					snd_idle_pct = 47;
					stall_pct <= 0;
				end
				2: begin
					snd_idle_pct = 0;
					stall_pct <= 47;
				end
				default: begin
					snd_idle_pct = 19;
					stall_pct <= 19;
				end
			endcase
			run_branch_mix(PHASE_ITEMS);
		end
		drain_answers();
	endtask

	always @(posedge clk)
		out_ready <= !hold_on && ($urandom_range(0, 99) >= stall_pct);

	// long receiver hold-off, counted here while the sender keeps offering
	initial begin
		forever begin
			wait (hold_req);
			hold_on <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_on <= 1'b0;
			hold_req = 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				report_mismatch("result beat with nothing outstanding", out_data, 0);
			end else begin
				want = answers_due.pop_front();
				if (out_data.table_index !== want.table_index)
					report_mismatch("table_index", out_data.table_index, want.table_index);
				if (out_data.predict_taken !== want.predict_taken)
					report_mismatch("predict_taken", out_data.predict_taken,
						want.predict_taken);
				if (out_data.target_found !== want.target_found)
					report_mismatch("target_found", out_data.target_found, want.target_found);
				if (out_data.predicted_target !== want.predicted_target)
					report_mismatch("predicted_target", out_data.predicted_target,
						want.predicted_target);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_MAX) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < TABLE_ENTRIES_DEF; i++) pht[i] = CTR_INIT;
		for (int i = 0; i < BTB_ENTRIES_DEF; i++) begin
			btb_tags[i] = '0;
			btb_tgts[i] = '0;
			btb_vld[i]  = 1'b0;
		end
		ghist   = '0;
		btb_ptr = '0;
		btb_cfg = CFG_RESET;
		// branch pool: some share hash bits with a neighbor, some sit at the top
		for (int i = 0; i < POOL_SIZE; i++) begin
			pc_pool[i] = $urandom;
			if (i % 6 == 5) pc_pool[i] = {$urandom_range(0, 1) ? 19'h7FFFF : 19'($urandom),
				pc_pool[i-1][12:0]};
			tgt_pool[i]  = $urandom;
			bias_pool[i] = $urandom_range(0, 100);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_counters_and_btb();
		test_btb_capacity_edges();
		test_output_backpressure();
		test_random_phases();
		drain_answers();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (n_err == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
